>>> design/poau_pkg.sv
// shared types, constants and sizes for the orbit attractor particle update
package poau_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int SQRT_STEPS  = 32;
  localparam int UNIT_BITS   = 31;

  localparam logic CMD_FRAME    = 1'b0;
  localparam logic CMD_PARTICLE = 1'b1;

  localparam logic [30:0] STRENGTH_RESET = 31'd65536;
  localparam logic [63:0] TENTH_Q32      = 64'd429496730;

  // dt = diff * 2^24 / 1000 = diff * 16777 + floor(diff * 27 / 125)
  localparam logic [31:0] DT_MAX_DIFF = 32'd255999;
  localparam logic [31:0] MS_WHOLE    = 32'd16777;
  localparam logic [22:0] MS_FRAC     = 23'd27;
  localparam logic [46:0] RECIP_125   = 47'd8589934;
  localparam logic [23:0] DIV_125     = 24'd125;

  typedef struct packed {
    logic            vld;
    logic            frm;
    logic            live;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [15:0]     life;
    logic [31:0]     dt;
  } item_t;

  typedef struct packed {
    item_t           it;
    logic [63:0]     sq;
    logic [2:0][31:0] mag;
  } front_t;

  typedef struct packed {
    item_t           it;
    logic [2:0][31:0] mag;
    logic [31:0]     len;
    logic [31:0]     k;
  } root_t;

  typedef struct packed {
    item_t                      it;
    logic [31:0]                k;
    logic [2:0][UNIT_BITS-1:0]  u;
  } unit_t;

endpackage

>>> design/poau_front.sv
// entry stages: life decay, frame step, magnitudes and squared radius
module poau_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic                  command,
  input  logic [31:0]           time_ms,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    pos_z,
  input  logic signed [31:0]    vel_x,
  input  logic signed [31:0]    vel_y,
  input  logic signed [31:0]    vel_z,
  input  logic signed [15:0]    life_in,
  input  logic [14:0]           decay,
  input  logic                  dead_in,
  output poau_pkg::front_t      out_stage
);

  typedef struct packed {
    poau_pkg::item_t it;
    logic [31:0]     diff;
  } fa_t;

  typedef struct packed {
    poau_pkg::item_t  it;
    logic [2:0][31:0] mag;
    logic             sat;
    logic [31:0]      base;
    logic [22:0]      w;
  } fb_t;

  typedef struct packed {
    poau_pkg::item_t  it;
    logic [2:0][63:0] sqm;
    logic [2:0][31:0] mag;
    logic             sat;
    logic [31:0]      base;
    logic [22:0]      w;
    logic [46:0]      qm;
  } fc_t;

  typedef struct packed {
    poau_pkg::item_t  it;
    logic [63:0]      sq;
    logic [2:0][31:0] mag;
    logic             sat;
    logic [31:0]      base;
    logic [16:0]      q;
  } fd_t;

  logic [31:0] prev_time;
  logic [31:0] step_dt;
  logic [16:0] life_wide;
  logic [15:0] life_sat;
  logic        life_pos;
  fa_t sa, sa_next;
  fb_t sb, sb_next;
  fc_t sc, sc_next;
  fd_t sd, sd_next;
  poau_pkg::front_t se_next;
  logic [16:0] q0;
  logic [23:0] rem;
  logic [31:0] dt_frame;

  // life after decay, saturated at the negative limit
  assign life_wide = {life_in[15], life_in} - {2'b00, decay};
  assign life_sat  = (life_wide[16] && !life_wide[15]) ? 16'h8000 : life_wide[15:0];
  assign life_pos  = !life_wide[16] && (life_wide != 17'd0);

  always_comb begin
    sa_next.it.vld  = in_valid;
    sa_next.it.frm  = (command == poau_pkg::CMD_FRAME);
    sa_next.it.live = (command == poau_pkg::CMD_PARTICLE) && !dead_in && life_pos;
    sa_next.it.pos  = {pos_z, pos_y, pos_x};
    sa_next.it.vel  = {vel_z, vel_y, vel_x};
    sa_next.it.life = life_sat;
    sa_next.it.dt   = '0;
    sa_next.diff    = time_ms - prev_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
    end else if (en && in_valid && (command == poau_pkg::CMD_FRAME)) begin
      prev_time <= time_ms;
    end
  end

  always_comb begin
    sb_next.it = sa.it;
    for (int i = 0; i < 3; i++) begin
      sb_next.mag[i] = sa.it.pos[i][31] ? (32'd0 - sa.it.pos[i]) : sa.it.pos[i];
    end
    sb_next.sat  = (sa.diff > poau_pkg::DT_MAX_DIFF);
    sb_next.base = {14'd0, sa.diff[17:0]} * poau_pkg::MS_WHOLE;
    sb_next.w    = {5'd0, sa.diff[17:0]} * poau_pkg::MS_FRAC;
  end

  always_comb begin
    sc_next.it   = sb.it;
    for (int i = 0; i < 3; i++) begin
      sc_next.sqm[i] = {32'd0, sb.mag[i]} * {32'd0, sb.mag[i]};
    end
    sc_next.mag  = sb.mag;
    sc_next.sat  = sb.sat;
    sc_next.base = sb.base;
    sc_next.w    = sb.w;
    sc_next.qm   = {24'd0, sb.w} * poau_pkg::RECIP_125;
  end

  // reciprocal estimate is at most one low, fixed by the remainder check
  assign q0  = sc.qm[46:30];
  assign rem = {1'b0, sc.w} - ({7'd0, q0} * poau_pkg::DIV_125);

  always_comb begin
    sd_next.it   = sc.it;
    sd_next.sq   = sc.sqm[0] + sc.sqm[1] + sc.sqm[2];
    sd_next.mag  = sc.mag;
    sd_next.sat  = sc.sat;
    sd_next.base = sc.base;
    sd_next.q    = q0 + {16'd0, (rem >= poau_pkg::DIV_125)};
  end

  assign dt_frame = sd.sat ? 32'hFFFF_FFFF : (sd.base + {15'd0, sd.q});

  always_comb begin
    se_next.it    = sd.it;
    se_next.it.dt = step_dt;
    se_next.sq    = sd.sq;
    se_next.mag   = sd.mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_dt <= '0;
    end else if (en && sd.it.vld && sd.it.frm) begin
      step_dt <= dt_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.it.vld        <= 1'b0;
      sb.it.vld        <= 1'b0;
      sc.it.vld        <= 1'b0;
      sd.it.vld        <= 1'b0;
      out_stage.it.vld <= 1'b0;
    end else if (en) begin
      sa        <= sa_next;
      sb        <= sb_next;
      sc        <= sc_next;
      sd        <= sd_next;
      out_stage <= se_next;
    end
  end

endmodule

>>> design/poau_root.sv
// pipelined square root of the squared radius alongside the strength divide
module poau_root (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [30:0]       strength,
  input  poau_pkg::front_t  in_stage,
  output poau_pkg::root_t   out_stage
);

  typedef struct packed {
    poau_pkg::item_t  it;
    logic [2:0][31:0] mag;
    logic [63:0]      rad;
    logic [31:0]      root;
    logic [33:0]      rem;
    logic [63:0]      den;
    logic [63:0]      drem;
    logic [31:0]      quo;
    logic             ksat;
  } rs_t;

  rs_t st [poau_pkg::SQRT_STEPS+1];
  rs_t st0_next;

  // one root bit and one quotient bit
  function automatic rs_t root_step(rs_t s);
    rs_t         r;
    logic [35:0] trial;
    logic [35:0] tst;
    logic [64:0] dr;
    r     = s;
    trial = {s.rem, s.rad[63:62]};
    tst   = {2'b00, s.root, 2'b01};
    if (trial >= tst) begin
      r.rem  = 34'(trial - tst);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = trial[33:0];
      r.root = {s.root[30:0], 1'b0};
    end
    r.rad = {s.rad[61:0], 2'b00};
    dr    = {s.drem, 1'b0};
    if (dr >= {1'b0, s.den}) begin
      r.drem = 64'(dr - {1'b0, s.den});
      r.quo  = {s.quo[30:0], 1'b1};
    end else begin
      r.drem = dr[63:0];
      r.quo  = {s.quo[30:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    st0_next.it   = in_stage.it;
    st0_next.mag  = in_stage.mag;
    st0_next.rad  = in_stage.sq;
    st0_next.root = '0;
    st0_next.rem  = '0;
    st0_next.den  = in_stage.sq + poau_pkg::TENTH_Q32;
    st0_next.drem = {33'd0, strength};
    st0_next.quo  = '0;
    st0_next.ksat = ({33'd0, strength} >= st0_next.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].it.vld <= 1'b0;
    end else if (en) begin
      st[0] <= st0_next;
    end
  end

  for (genvar g = 0; g < poau_pkg::SQRT_STEPS; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        st[g+1].it.vld <= 1'b0;
      end else if (en) begin
        st[g+1] <= root_step(st[g]);
      end
    end
  end

  always_comb begin
    out_stage.it  = st[poau_pkg::SQRT_STEPS].it;
    out_stage.mag = st[poau_pkg::SQRT_STEPS].mag;
    out_stage.len = st[poau_pkg::SQRT_STEPS].root;
    out_stage.k   = st[poau_pkg::SQRT_STEPS].ksat ? 32'hFFFF_FFFF :
                    st[poau_pkg::SQRT_STEPS].quo;
  end

endmodule

>>> design/poau_unit.sv
// three-lane pipelined divide giving the unit vector in Q1.30
module poau_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  poau_pkg::root_t  in_stage,
  output poau_pkg::unit_t  out_stage
);

  typedef struct packed {
    poau_pkg::item_t                     it;
    logic [31:0]                         len;
    logic [31:0]                         k;
    logic                                zero;
    logic [2:0][31:0]                    rem;
    logic [2:0][poau_pkg::UNIT_BITS-1:0] u;
  } us_t;

  us_t st [poau_pkg::UNIT_BITS];
  us_t st0_next;

  function automatic us_t unit_step(us_t s);
    us_t         r;
    logic [32:0] r2;
    logic        ge;
    r = s;
    for (int i = 0; i < 3; i++) begin
      r2 = {s.rem[i], 1'b0};
      ge = (r2 >= {1'b0, s.len});
      r.rem[i] = ge ? 32'(r2 - {1'b0, s.len}) : r2[31:0];
      r.u[i]   = {s.u[i][poau_pkg::UNIT_BITS-2:0], ge};
    end
    return r;
  endfunction

  // top quotient bit: magnitude never exceeds the radius
  always_comb begin
    st0_next.it   = in_stage.it;
    st0_next.len  = in_stage.len;
    st0_next.k    = in_stage.k;
    st0_next.zero = (in_stage.len == 32'd0);
    for (int i = 0; i < 3; i++) begin
      if (in_stage.mag[i] >= in_stage.len) begin
        st0_next.rem[i] = in_stage.mag[i] - in_stage.len;
        st0_next.u[i]   = {{(poau_pkg::UNIT_BITS-1){1'b0}}, 1'b1};
      end else begin
        st0_next.rem[i] = in_stage.mag[i];
        st0_next.u[i]   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].it.vld <= 1'b0;
    end else if (en) begin
      st[0] <= st0_next;
    end
  end

  for (genvar g = 0; g < poau_pkg::UNIT_BITS - 1; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        st[g+1].it.vld <= 1'b0;
      end else if (en) begin
        st[g+1] <= unit_step(st[g]);
      end
    end
  end

  always_comb begin
    out_stage.it = st[poau_pkg::UNIT_BITS-1].it;
    out_stage.k  = st[poau_pkg::UNIT_BITS-1].k;
    out_stage.u  = st[poau_pkg::UNIT_BITS-1].zero ? '0 : st[poau_pkg::UNIT_BITS-1].u;
  end

endmodule

>>> design/poau_back.sv
// acceleration, velocity and position update stages
module poau_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  poau_pkg::unit_t  in_stage,
  output poau_pkg::item_t  out_stage
);

  typedef struct packed {
    poau_pkg::item_t  it;
    logic [2:0][39:0] acc;
  } bk_t;

  bk_t b0, b1, b2, b3, b4;
  bk_t b0_next, b1_next, b2_next, b3_next, b4_next;
  poau_pkg::item_t b5_next;
  logic [2:0][63:0] p0;
  logic [2:0][63:0] p1;
  logic [2:0][63:0] p4;

  function automatic logic [31:0] sat_add(logic [31:0] base, logic neg, logic [39:0] d);
    logic signed [41:0] wide;
    logic [31:0]        res;
    if (neg) begin
      wide = {{10{base[31]}}, base} - {2'b00, d};
    end else begin
      wide = {{10{base[31]}}, base} + {2'b00, d};
    end
    if (wide > 42'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (wide < -42'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = wide[31:0];
    end
    return res;
  endfunction

  always_comb begin
    b0_next.it = in_stage.it;
    for (int i = 0; i < 3; i++) begin
      p0[i] = {32'd0, in_stage.k} * {33'd0, in_stage.u[i]};
      b0_next.acc[i] = {6'd0, p0[i][63:30]};
    end
  end

  always_comb begin
    b1_next.it = b0.it;
    for (int i = 0; i < 3; i++) begin
      p1[i] = {32'd0, b0.acc[i][31:0]} * {32'd0, b0.it.dt};
      b1_next.acc[i] = p1[i][63:24];
    end
  end

  // acceleration points toward the origin
  always_comb begin
    b2_next = b1;
    for (int i = 0; i < 3; i++) begin
      b2_next.it.vel[i] = sat_add(b1.it.vel[i],
                                  !b1.it.pos[i][31] && (b1.it.pos[i] != 32'd0),
                                  b1.acc[i]);
    end
  end

  always_comb begin
    b3_next.it = b2.it;
    for (int i = 0; i < 3; i++) begin
      b3_next.acc[i] = {8'd0, (b2.it.vel[i][31] ? (32'd0 - b2.it.vel[i]) : b2.it.vel[i])};
    end
  end

  always_comb begin
    b4_next.it = b3.it;
    for (int i = 0; i < 3; i++) begin
      p4[i] = {32'd0, b3.acc[i][31:0]} * {32'd0, b3.it.dt};
      b4_next.acc[i] = p4[i][63:24];
    end
  end

  always_comb begin
    b5_next = b4.it;
    for (int i = 0; i < 3; i++) begin
      b5_next.pos[i] = sat_add(b4.it.pos[i], b4.it.vel[i][31], b4.acc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0.it.vld     <= 1'b0;
      b1.it.vld     <= 1'b0;
      b2.it.vld     <= 1'b0;
      b3.it.vld     <= 1'b0;
      b4.it.vld     <= 1'b0;
      out_stage.vld <= 1'b0;
    end else if (en) begin
      b0        <= b0_next;
      b1        <= b1_next;
      b2        <= b2_next;
      b3        <= b3_next;
      b4        <= b4_next;
      out_stage <= b5_next;
    end
  end

endmodule

>>> design/particle_orbit_attractor_update.sv
// top level: orbit attractor particle update with output queue and live count
//
// Input channel (in_valid/in_ready) takes one transaction per cycle while
// in_ready is high: a frame start (command 0, time_ms) or a particle
// (command 1 with position, velocity, life, decay and dead flag). Frame
// starts and dropped particles give no result; each live particle gives one
// transaction on out_valid/out_ready. The path from acceptance to out_valid
// holds 76 register stages, most of them in the 32-step root/strength-divide
// pipeline and the 31-step unit-vector divide.
// A two-entry output queue (output register plus skid) sits after the
// pipeline; the whole pipeline advances while the skid entry is empty, so a
// stalled receiver drops in_ready right after the edge that fills the queue.
// cfg_we writes cfg_wdata into the strength register; write only when idle.
// Synchronous reset empties the pipeline and queue, clears the frame time,
// step and live count, and sets the strength to 1.0.
module particle_orbit_attractor_update (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [31:0]          time_ms,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   pos_z,
  input  logic signed [31:0]   vel_x,
  input  logic signed [31:0]   vel_y,
  input  logic signed [31:0]   vel_z,
  input  logic signed [15:0]   life_in,
  input  logic [14:0]          decay,
  input  logic                 dead_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   new_pos_x,
  output logic signed [31:0]   new_pos_y,
  output logic signed [31:0]   new_pos_z,
  output logic signed [31:0]   new_vel_x,
  output logic signed [31:0]   new_vel_y,
  output logic signed [31:0]   new_vel_z,
  output logic signed [15:0]   life_out,
  output logic [15:0]          active_count,
  input  logic                 cfg_we,
  input  logic [30:0]          cfg_wdata
);

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [15:0]      life;
    logic [15:0]      count;
  } res_t;

  logic [30:0] strength;
  logic        en;
  logic        push;
  logic        pop;
  logic [poau_pkg::COUNT_WIDTH-1:0] live_count;
  logic [poau_pkg::COUNT_WIDTH-1:0] count_next;
  logic [31:0] count_ext;
  res_t        push_data;
  res_t        out_reg;
  res_t        skid;
  logic        skid_valid;

  poau_pkg::front_t f_out;
  poau_pkg::root_t  r_out;
  poau_pkg::unit_t  u_out;
  poau_pkg::item_t  b_out;

  assign en       = !skid_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= poau_pkg::STRENGTH_RESET;
    end else if (cfg_we) begin
      strength <= cfg_wdata;
    end
  end

  poau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .command   (command),
    .time_ms   (time_ms),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .life_in   (life_in),
    .decay     (decay),
    .dead_in   (dead_in),
    .out_stage (f_out)
  );

  poau_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .strength  (strength),
    .in_stage  (f_out),
    .out_stage (r_out)
  );

  poau_unit u_unit (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_stage  (r_out),
    .out_stage (u_out)
  );

  poau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_stage  (u_out),
    .out_stage (b_out)
  );

  // running live count, saturating
  assign count_next = (live_count == '1) ? live_count : (live_count + 1'b1);
  assign count_ext  = 32'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
    end else if (en && b_out.vld) begin
      if (b_out.frm) begin
        live_count <= '0;
      end else if (b_out.live) begin
        live_count <= count_next;
      end
    end
  end

  assign push = en && b_out.vld && !b_out.frm && b_out.live;
  assign pop  = out_valid && out_ready;

  always_comb begin
    push_data.pos   = b_out.pos;
    push_data.vel   = b_out.vel;
    push_data.life  = b_out.life;
    push_data.count = (count_ext > 32'h0000_FFFF) ? 16'hFFFF : count_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_reg <= skid_valid ? skid : push_data;
    end
    if (out_valid && !pop && push) begin
      skid <= push_data;
    end
  end

  assign new_pos_x    = out_reg.pos[0];
  assign new_pos_y    = out_reg.pos[1];
  assign new_pos_z    = out_reg.pos[2];
  assign new_vel_x    = out_reg.vel[0];
  assign new_vel_y    = out_reg.vel[1];
  assign new_vel_z    = out_reg.vel[2];
  assign life_out     = out_reg.life;
  assign active_count = out_reg.count;

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid)
    else $error("skid entry lost while receiver stalled");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> active_count != 16'd0)
    else $error("result presented with zero active count");
`endif

endmodule
